// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the binning unit RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PGB_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

`define PGB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define PGB_ASSERT(lbl, clk, rstn, prop)

`define PGB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hw/rtl/pgb_pkg.sv =====
// Constants, types and index functions of the particle grid binning unit.
// No dependencies; imported by every other file but assert_macros.svh.
package pgb_pkg;

	localparam int MAX_AXIS_CELLS = 16;
	localparam int SLOTS_PER_CELL = 16;

	localparam int COORD_W    = 16;
	localparam int DIM_W      = 5;
	localparam int CELL_NUM_W = 12;
	localparam int SLOT_NUM_W = 4;
	localparam int POS_W      = 3 * COORD_W;

	localparam int AXIS_MAX_W  = $clog2(MAX_AXIS_CELLS + 1);
	localparam int IDX_W       = (MAX_AXIS_CELLS > 1) ? $clog2(MAX_AXIS_CELLS) : 1;
	localparam int DSQ_W       = $clog2(MAX_AXIS_CELLS * MAX_AXIS_CELLS + 1);
	localparam int GRID_CELLS  = MAX_AXIS_CELLS * MAX_AXIS_CELLS * MAX_AXIS_CELLS;
	localparam int CELL_W      = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
	localparam int CNT_W       = $clog2(SLOTS_PER_CELL + 1);
	localparam int STORE_DEPTH = GRID_CELLS * SLOTS_PER_CELL;
	localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_CELLS_PER_AXIS = 1'b0;
	localparam logic [DIM_W-1:0] CELLS_PER_AXIS_RESET = DIM_W'(16);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	typedef struct packed {
		logic              op;
		logic [CELL_W-1:0] cell_idx;
		logic [POS_W-1:0]  pos;
	} pgb_rec_t;

	function automatic logic [AXIS_MAX_W-1:0] axis_dim(input logic [DIM_W-1:0] raw);
		logic [AXIS_MAX_W-1:0] d;
		if (raw == '0) begin
			d = AXIS_MAX_W'(1);
		end else if (int'(raw) > MAX_AXIS_CELLS) begin
			d = AXIS_MAX_W'(MAX_AXIS_CELLS);
		end else begin
			d = AXIS_MAX_W'(raw);
		end
		return d;
	endfunction

	function automatic logic [IDX_W-1:0] axis_index(input logic [COORD_W-1:0] c,
			input logic [AXIS_MAX_W-1:0] d);
		logic [COORD_W-1:0] off;
		logic [COORD_W+AXIS_MAX_W-1:0] prod;
		logic [AXIS_MAX_W-1:0] i;
		off  = c ^ {1'b1, {(COORD_W-1){1'b0}}};
		prod = (COORD_W+AXIS_MAX_W)'(off) * (COORD_W+AXIS_MAX_W)'(d);
		i    = prod[COORD_W +: AXIS_MAX_W];
		if (i >= d) begin
			i = d - AXIS_MAX_W'(1);
		end
		return IDX_W'(i);
	endfunction

endpackage

// ===== hw/rtl/pgb_ifs.sv =====
// Valid/ready channel interfaces for particle requests and binning results.
// Depends on pgb_pkg for field widths.
interface pgb_item_if import pgb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;

	modport source (output valid, opcode, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, opcode, pos_x, pos_y, pos_z, output ready);
endinterface

interface pgb_result_if import pgb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CELL_NUM_W-1:0] cell_number;
	logic [SLOT_NUM_W-1:0] slot_used;
	logic                  stored;
	logic                  cell_full;

	modport source (output valid, cell_number, slot_used, stored, cell_full, input ready);
	modport sink (input valid, cell_number, slot_used, stored, cell_full, output ready);
endinterface

// ===== hw/rtl/pgb_front.sv =====
// Front end: accepts requests, computes axis indices and the linear cell number.
// Depends on pgb_pkg and pgb_ifs; feeds the request queue.
module pgb_front import pgb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DIM_W-1:0]   cells_per_axis,
	input  logic               init_busy,
	pgb_item_if.sink           items,
	output pgb_rec_t           rec,
	output logic               rec_valid,
	input  logic               rec_ready
);

	logic [AXIS_MAX_W-1:0]   dim;
	logic [2*AXIS_MAX_W-1:0] dsq_full;
	logic [DSQ_W-1:0]        dsq_q;

	logic                    v_s1;
	logic                    op_s1;
	logic [IDX_W-1:0]        ix_s1;
	logic [IDX_W-1:0]        iy_s1;
	logic [IDX_W-1:0]        iz_s1;
	logic [POS_W-1:0]        pos_s1;

	logic                    v_s2;
	pgb_rec_t                rec_s2;

	logic                    adv1;
	logic                    adv2;
	logic                    take;
	logic [CELL_W+1:0]       sum;
	logic [CELL_W-1:0]       cell_num;

	assign dim      = axis_dim(cells_per_axis);
	assign dsq_full = {{AXIS_MAX_W{1'b0}}, dim} * {{AXIS_MAX_W{1'b0}}, dim};

	assign adv2        = !v_s2 || rec_ready;
	assign adv1        = !v_s1 || adv2;
	assign items.ready = adv1 && !init_busy;
	assign take        = items.valid && items.ready;

	always_comb begin
		sum = (CELL_W+2)'(ix_s1) * (CELL_W+2)'(dsq_q)
			+ (CELL_W+2)'(iy_s1) * (CELL_W+2)'(dim)
			+ (CELL_W+2)'(iz_s1);
		if (sum >= (CELL_W+2)'(GRID_CELLS)) begin
			cell_num = CELL_W'(GRID_CELLS - 1);
		end else begin
			cell_num = sum[CELL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		dsq_q <= dsq_full[DSQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= take;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && take) begin
			op_s1  <= items.opcode;
			ix_s1  <= axis_index(items.pos_x, dim);
			iy_s1  <= axis_index(items.pos_y, dim);
			iz_s1  <= axis_index(items.pos_z, dim);
			pos_s1 <= {items.pos_x, items.pos_y, items.pos_z};
		end
		if (adv2 && v_s1) begin
			rec_s2.op       <= op_s1;
			rec_s2.cell_idx <= cell_num;
			rec_s2.pos      <= pos_s1;
		end
	end

	assign rec       = rec_s2;
	assign rec_valid = v_s2;

endmodule

// ===== hw/rtl/pgb_queue.sv =====
// Short request queue between the front end and the cell update engine.
// Depends on pgb_pkg for the record type and depth.
module pgb_queue import pgb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  pgb_rec_t wr_data,
	input  logic     wr_valid,
	output logic     wr_ready,
	output pgb_rec_t rd_data,
	output logic     rd_valid,
	input  logic     rd_ready
);

	pgb_rec_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign wr_ready = count_q != QCNT_W'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = entry_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + QPTR_W'(1);
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/pgb_back.sv =====
// Cell update engine: count read-modify-write, slot store writes, clear sweeps.
// Depends on pgb_pkg and pgb_ifs; drains the request queue.
module pgb_back import pgb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  pgb_rec_t rec,
	input  logic     rec_valid,
	output logic     rec_ready,
	pgb_result_if.source results,
	output logic     init_busy
);

	localparam logic [1:0] ST_SWEEP = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_RMW   = 2'd2;

	logic [CNT_W-1:0] count_mem [GRID_CELLS];
	logic [POS_W-1:0] slot_mem [STORE_DEPTH];

	logic [1:0]            state_q;
	logic [CELL_W-1:0]     sweep_q;
	logic                  emit_q;
	pgb_rec_t              cur_q;
	logic [CNT_W-1:0]      rd_cnt_q;

	logic                  out_v_q;
	logic [CELL_NUM_W-1:0] cell_q;
	logic [SLOT_NUM_W-1:0] slot_q;
	logic                  stored_q;
	logic                  full_q;

	logic                  out_free;
	logic                  pop;
	logic                  room;
	logic                  sweep_last;
	logic                  cnt_we;
	logic [CELL_W-1:0]     cnt_wa;
	logic [CNT_W-1:0]      cnt_wd;
	logic                  st_we;
	logic [STORE_AW-1:0]   st_addr;

	assign out_free   = !out_v_q || results.ready;
	assign rec_ready  = (state_q == ST_IDLE) && out_free;
	assign pop        = rec_valid && rec_ready;
	assign room       = rd_cnt_q < CNT_W'(SLOTS_PER_CELL);
	assign sweep_last = sweep_q == CELL_W'(GRID_CELLS - 1);
	assign init_busy  = (state_q == ST_SWEEP) && !emit_q;

	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = cur_q.cell_idx;
		cnt_wd = rd_cnt_q + CNT_W'(1);
		case (state_q)
			ST_SWEEP: begin
				cnt_we = 1'b1;
				cnt_wa = sweep_q;
				cnt_wd = '0;
			end
			ST_RMW: begin
				cnt_we = room;
			end
			default: begin
				cnt_we = 1'b0;
			end
		endcase
	end

	assign st_we   = (state_q == ST_RMW) && room;
	assign st_addr = STORE_AW'(cur_q.cell_idx) * STORE_AW'(SLOTS_PER_CELL)
		+ STORE_AW'(rd_cnt_q);

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem[cnt_wa] <= cnt_wd;
		end
		if (pop) begin
			rd_cnt_q <= count_mem[rec.cell_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			slot_mem[st_addr] <= cur_q.pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_q <= '0;
			emit_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (((state_q == ST_SWEEP) && sweep_last && emit_q) || (state_q == ST_RMW)) begin
				out_v_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_SWEEP: begin
					if (sweep_last) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + CELL_W'(1);
					end
				end
				ST_IDLE: begin
					if (pop) begin
						if (rec.op == OP_CLEAR) begin
							state_q <= ST_SWEEP;
							sweep_q <= '0;
							emit_q  <= 1'b1;
						end else begin
							state_q <= ST_RMW;
						end
					end
				end
				ST_RMW: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rec;
		end
		if (state_q == ST_RMW) begin
			cell_q   <= CELL_NUM_W'(cur_q.cell_idx);
			slot_q   <= room ? SLOT_NUM_W'(rd_cnt_q) : '0;
			stored_q <= room;
			full_q   <= !room;
		end else if ((state_q == ST_SWEEP) && sweep_last) begin
			cell_q   <= '0;
			slot_q   <= '0;
			stored_q <= 1'b0;
			full_q   <= 1'b0;
		end
	end

	assign results.valid       = out_v_q;
	assign results.cell_number = cell_q;
	assign results.slot_used   = slot_q;
	assign results.stored      = stored_q;
	assign results.cell_full   = full_q;

endmodule

// ===== hw/rtl/particle_grid_binning_unit.sv =====
// Top level of the particle grid binning unit: APB register, front end, queue, engine.
// Depends on pgb_pkg, pgb_ifs, pgb_front, pgb_queue, pgb_back and assert_macros.svh.
//
// Bins Q1.15 particle positions into a cubic grid of cells_per_axis cells per axis
// (0 acts as 1, values above 16 act as 16) and reports one result per request.
// The front end registers the axis indices, then the linear cell number, in its
// pipeline; the cell engine reads the count memory in IDLE, then writes the count
// and the slot store in RMW, and takes the next request only back in IDLE with its
// result register free. A clear walks the 4096-entry count memory one cell per
// cycle; its all-zero result appears at the end of the walk. After reset the same
// walk runs once with items.ready held low; register writes are taken throughout.
// Up to two requests queue between front end and engine.
`include "assert_macros.svh"

module particle_grid_binning_unit import pgb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	pgb_item_if.sink           items,
	pgb_result_if.source       results
);

	logic [DIM_W-1:0] cells_per_axis_q;
	logic             init_busy;

	pgb_rec_t         f_rec;
	logic             f_valid;
	logic             f_ready;
	pgb_rec_t         q_rec;
	logic             q_valid;
	logic             q_ready;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_per_axis_q <= CELLS_PER_AXIS_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CELLS_PER_AXIS)) begin
			cells_per_axis_q <= pwdata[DIM_W-1:0];
		end
	end

	always_comb begin
		if (paddr[2] == REG_CELLS_PER_AXIS) begin
			prdata = PDATA_W'(cells_per_axis_q);
		end else begin
			prdata = '0;
		end
	end

	pgb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cells_per_axis (cells_per_axis_q),
		.init_busy      (init_busy),
		.items          (items),
		.rec            (f_rec),
		.rec_valid      (f_valid),
		.rec_ready      (f_ready)
	);

	pgb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (f_rec),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.rd_data  (q_rec),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	pgb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (q_rec),
		.rec_valid (q_valid),
		.rec_ready (q_ready),
		.results   (results),
		.init_busy (init_busy)
	);

	`PGB_ASSERT(a_no_take_during_init, clk, arst_n, init_busy |-> !items.ready)
	`PGB_ASSERT(a_single_outcome, clk, arst_n, results.valid |-> !(results.stored && results.cell_full))
	`PGB_ASSERT(a_clear_all_zero, clk, arst_n, (results.valid && !results.stored && !results.cell_full) |-> (results.cell_number == '0 && results.slot_used == '0))
	`PGB_ASSERT(a_drop_no_slot, clk, arst_n, (results.valid && results.cell_full) |-> (results.slot_used == '0))
	`PGB_ASSERT_NEXT(a_init_once, clk, arst_n, !init_busy, !init_busy)

endmodule

// ===== test/tb_particle_grid_binning_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of particle_grid_binning_unit: drives insert/clear requests and
// APB grid-size writes, predicts every result with its own cell-count model. Depends on
// pgb_pkg, the pgb_item_if/pgb_result_if channels and the binning unit RTL.
module tb_particle_grid_binning_unit;
	import pgb_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int MAX_REPORTS    = 10;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASE_ITEMS    = 100;

	typedef struct packed {
		logic [CELL_NUM_W-1:0] cell_number;
		logic [SLOT_NUM_W-1:0] slot_used;
		logic                  stored;
		logic                  cell_full;
	} bin_result_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	pgb_item_if   item_ch ();
	pgb_result_if res_ch ();

	particle_grid_binning_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (item_ch),
		.results (res_ch)
	);

	logic [DIM_W-1:0]   grid_dim_reg;
	logic [CNT_W-1:0]   cell_fill [GRID_CELLS];
	bin_result_t        expected_bins [$];
	bin_result_t        got_bin;
	bin_result_t        want_bin;
	logic [COORD_W-1:0] hot_x [3];
	logic [COORD_W-1:0] hot_y [3];
	logic [COORD_W-1:0] hot_z [3];
	int                 mismatches;
	int                 inserts_sent;
	int                 drops_seen;
	int                 clears_sent;
	int                 reg_writes;
	int                 stall_left;
	int                 quiet_cycles;
	bit                 idle_on;
	bit                 allow_idle;

	always #2 clk = ~clk;

	function automatic int effective_dim(input logic [DIM_W-1:0] raw);
		if (raw == '0)
			return 1;
		if (int'(raw) > MAX_AXIS_CELLS)
			return MAX_AXIS_CELLS;
		return int'(raw);
	endfunction

	function automatic int grid_index(input logic [COORD_W-1:0] c, input int d);
		logic [31:0] off;
		int i;
		off = 32'(c ^ {1'b1, {(COORD_W-1){1'b0}}});
		i = int'((off * 32'(d)) >> COORD_W);
		if (i >= d)
			i = d - 1;
		return i;
	endfunction

	function automatic void bin_particle(input logic op, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		bin_result_t r;
		int d;
		int cell_id;
		r = '0;
		if (op == OP_CLEAR) begin
			foreach (cell_fill[k])
				cell_fill[k] = '0;
			clears_sent++;
		end else begin
			d = effective_dim(grid_dim_reg);
			cell_id = grid_index(x, d) * d * d + grid_index(y, d) * d + grid_index(z, d);
			r.cell_number = CELL_NUM_W'(cell_id);
			if (int'(cell_fill[cell_id]) < SLOTS_PER_CELL) begin
				r.slot_used = SLOT_NUM_W'(cell_fill[cell_id]);
				r.stored = 1'b1;
				cell_fill[cell_id] = cell_fill[cell_id] + 1'b1;
			end else begin
				r.cell_full = 1'b1;
				drops_seen++;
			end
			inserts_sent++;
		end
		expected_bins.push_back(r);
	endfunction

	task automatic send_request(input logic op, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 17);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid  <= 1'b1;
		item_ch.opcode <= op;
		item_ch.pos_x  <= x;
		item_ch.pos_y  <= y;
		item_ch.pos_z  <= z;
		do @(posedge clk); while (!item_ch.ready);
		bin_particle(op, x, y, z);
	endtask

	task automatic wait_results_drained();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_bins.size() != 0);
	endtask

	task automatic write_grid_dim(input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * int'(REG_CELLS_PER_AXIS));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		grid_dim_reg = value[DIM_W-1:0];
		reg_writes++;
	endtask

	task automatic test_coordinate_extremes();
		write_grid_dim(PDATA_W'(MAX_AXIS_CELLS));
		send_request(OP_INSERT, 16'h8000, 16'h8000, 16'h8000);
		send_request(OP_INSERT, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_request(OP_INSERT, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_INSERT, 16'hFFFF, 16'h0001, 16'h8000);
		send_request(OP_INSERT, 16'h7FFF, 16'h8000, 16'h0000);
		send_request(OP_INSERT, 16'h4000, 16'hC000, 16'h3FFF);
		wait_results_drained();
	endtask

	task automatic test_cell_overflow();
		write_grid_dim(PDATA_W'(1));
		repeat (17)
			send_request(OP_INSERT, 16'($urandom), 16'($urandom), 16'($urandom));
		send_request(OP_CLEAR, 16'h7FFF, 16'h8000, 16'h5A5A);
		send_request(OP_INSERT, 16'h1234, 16'h8765, 16'hFFFF);
		wait_results_drained();
	endtask

	task automatic random_request_mix(input int count);
		int sel;
		int h;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 39) == 0)
				idle_on = allow_idle && !idle_on;
			if ($urandom_range(0, 199) == 0)
				wait_results_drained();
			sel = $urandom_range(0, 99);
			h = $urandom_range(0, 2);
			if (sel < 2)
				send_request(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
			else if (sel < 60)
				send_request(OP_INSERT, hot_x[h] + 16'($urandom_range(0, 63)),
					hot_y[h] + 16'($urandom_range(0, 63)),
					hot_z[h] + 16'($urandom_range(0, 63)));
			else
				send_request(OP_INSERT, 16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	task automatic test_random_grid_sizes();
		int dims [10] = '{0, 31, 2, 17, 3, 5, 1, 8, 15, 16};
		foreach (dims[p]) begin
			if (p == 9) begin
				allow_idle = 1'b0;
				idle_on = 1'b0;
			end
			for (int h = 0; h < 3; h++) begin
				hot_x[h] = 16'($urandom);
				hot_y[h] = 16'($urandom);
				hot_z[h] = 16'($urandom);
			end
			write_grid_dim(($urandom & ~PDATA_W'(32'h1F)) | PDATA_W'(dims[p]));
			random_request_mix(PHASE_ITEMS);
			wait_results_drained();
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			stall_left   = 0;
			quiet_cycles = 0;
			res_ch.ready <= 1'b0;
		end else begin
			if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no request or result moved for %0d cycles", quiet_cycles);
				$display("Mismatches found");
				$finish;
			end else begin
				if (res_ch.valid && res_ch.ready) begin
					got_bin = {res_ch.cell_number, res_ch.slot_used, res_ch.stored,
						res_ch.cell_full};
					if (expected_bins.size() == 0) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("Unexpected result cell=%0d slot=%0d stored=%0b full=%0b",
								got_bin.cell_number, got_bin.slot_used, got_bin.stored,
								got_bin.cell_full);
					end else begin
						want_bin = expected_bins.pop_front();
						if (got_bin !== want_bin) begin
							mismatches++;
							if (mismatches <= MAX_REPORTS)
								$display({"Result mismatch: expected cell=%0d slot=%0d ",
									"stored=%0b full=%0b, got cell=%0d slot=%0d ",
									"stored=%0b full=%0b"},
									want_bin.cell_number, want_bin.slot_used,
									want_bin.stored, want_bin.cell_full,
									got_bin.cell_number, got_bin.slot_used,
									got_bin.stored, got_bin.cell_full);
						end
					end
				end
				if (stall_left > 0) begin
					stall_left--;
					res_ch.ready <= 1'b0;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					stall_left = $urandom_range(0, 16);
					res_ch.ready <= 1'b0;
				end else begin
					res_ch.ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.opcode <= OP_INSERT;
		item_ch.pos_x <= '0;
		item_ch.pos_y <= '0;
		item_ch.pos_z <= '0;
		grid_dim_reg = CELLS_PER_AXIS_RESET;
		foreach (cell_fill[k])
			cell_fill[k] = '0;
		mismatches = 0;
		inserts_sent = 0;
		drops_seen = 0;
		clears_sent = 0;
		reg_writes = 0;
		idle_on = 1'b1;
		allow_idle = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_coordinate_extremes();
		test_cell_overflow();
		test_random_grid_sizes();

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_bins.size() != 0)
			mismatches += expected_bins.size();
		$display("Binned %0d particles (%0d dropped on full cells) and ran %0d clears",
			inserts_sent, drops_seen, clears_sent);
		$display("across %0d grid-size writes, from 1 to 16 cells per axis",
			reg_writes);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
